[hw/rtl/caum_pkg.sv]
package caum_pkg;

  localparam int unsigned AccW  = 40;
  localparam int unsigned ByteW = 48;
  localparam int unsigned WinW  = 27;
  localparam int unsigned DivW  = 60;
  localparam int unsigned QW    = 60;
  localparam int unsigned RawW  = 58;

  typedef enum logic [2:0] {
    FN_STATE  = 3'd0,
    FN_CCA    = 3'd1,
    FN_TX     = 3'd2,
    FN_RX     = 3'd3,
    FN_REPORT = 3'd4,
    FN_START  = 3'd5,
    FN_STOP   = 3'd6
  } func_t;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TX   = 3'd2;
  localparam logic [2:0] ST_RX   = 3'd3;

  // division jobs issued by the sequencer
  typedef enum logic [2:0] {
    JOB_TX  = 3'd0,
    JOB_RX  = 3'd1,
    JOB_WC  = 3'd2,
    JOB_NC  = 3'd3,
    JOB_THR = 3'd4,
    JOB_SW  = 3'd5,
    JOB_SN  = 3'd6
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVENT,
    S_DIV_START,
    S_DIV_WAIT,
    S_MIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   ev_apply;   // apply accepted event to accumulators
    logic   div_start;
    job_t   job;
    logic   div_store;  // latch quotient of job
    logic   mix;        // compute scaling decision
    logic   finish;     // load output register, clear window
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_scale;   // report needs the two proportional divisions
    logic running;
  } sts_t;

endpackage

[hw/rtl/caum_divider.sv]
module caum_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [caum_pkg::DivW+16:0] dividend,
  input  logic [caum_pkg::DivW-1:0]  divisor,
  output logic                       done,
  output logic [caum_pkg::QW-1:0]    quotient
);
  import caum_pkg::*;

  localparam int unsigned NW = DivW + 17;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]   num;
  logic [DivW:0]   rem;
  logic [DivW-1:0] den;
  logic [NW-1:0]   q;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;

  assign trial = {rem[DivW-1:0], num[NW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        num <= {num[NW-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= diff;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotients of every job fit well below 2^60
  assign quotient = q[QW-1:0];

endmodule

[hw/rtl/caum_ctrl.sv]
module caum_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [2:0]       func,
  input  logic             out_free,
  input  caum_pkg::sts_t   sts,
  output caum_pkg::cmd_t   cmd,
  output logic             busy
);
  import caum_pkg::*;

  state_t state, state_next;
  job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_TX;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    cmd.job    = job;
    s_tready   = 1'b0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (func == FN_REPORT && sts.running) begin
            state_next = S_DIV_START;
            job_next   = JOB_TX;
          end else begin
            state_next = S_EVENT;
          end
        end
      end
      S_EVENT: begin
        cmd.ev_apply = 1'b1;
        state_next   = S_IDLE;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          case (job)
            JOB_THR: state_next = S_MIX;
            JOB_SN:  state_next = S_OUT;
            default: begin
              job_next   = job_t'(job + 3'd1);
              state_next = S_DIV_START;
            end
          endcase
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (sts.need_scale) begin
          job_next   = JOB_SW;
          state_next = S_DIV_START;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/caum_datapath.sv]
module caum_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_take,
  input  logic [2:0]                    func,
  input  logic [2:0]                    phy_state,
  input  logic                          wifi_caused,
  input  logic [31:0]                   duration_us,
  input  logic [15:0]                   packet_bytes,
  input  logic [13:0]                   interferer_pct,
  input  logic [caum_pkg::WinW-1:0]     window_us,
  input  caum_pkg::cmd_t                cmd,
  output caum_pkg::sts_t                sts,
  output logic [13:0]                   total_pct,
  output logic [13:0]                   wifi_pct,
  output logic [13:0]                   nonwifi_pct,
  output logic [15:0]                   tx_pct,
  output logic [15:0]                   rx_pct,
  output logic [15:0]                   wifi_cca_pct,
  output logic [15:0]                   nonwifi_cca_pct,
  output logic [31:0]                   throughput_centi_mbps,
  output logic [47:0]                   bytes_sent_out,
  output logic [47:0]                   bytes_received_out,
  output logic [39:0]                   idle_time_us
);
  import caum_pkg::*;

  localparam logic [AccW-1:0]  MaxAcc  = '1;
  localparam logic [ByteW-1:0] MaxByte = '1;

  logic            running;
  logic [AccW-1:0] idle_acc, tx_acc, rx_acc, wc_acc, nc_acc;
  logic [ByteW-1:0] sent_acc, recv_acc;

  // latched input item
  logic [2:0]  f_q, st_q;
  logic        wc_q;
  logic [31:0] dur_q;
  logic [15:0] pb_q;
  logic [13:0] vi_q;

  logic [QW-1:0]   txp, rxp, wcp, ncp, thr, sw, sn;
  logic [RawW-1:0] raw_wifi, raw_non, raw_total;
  logic [13:0]     avail;
  logic            scaled;

  logic [AccW:0]  dur_sum_add;
  logic [AccW-1:0] tgt;
  logic [AccW:0]  acc_sum;
  logic [ByteW:0] byte_sum;

  logic                divs_done;
  logic [DivW+16:0]    dividend;
  logic [DivW-1:0]     divisor;
  logic [QW-1:0]       quotient;
  logic [WinW-1:0]     eff_win;

  assign eff_win = (window_us == '0) ? WinW'(1) : window_us;

  always_ff @(posedge clk) begin
    if (in_take) begin
      f_q   <= func;
      st_q  <= phy_state;
      wc_q  <= wifi_caused;
      dur_q <= duration_us;
      pb_q  <= packet_bytes;
      vi_q  <= interferer_pct;
    end
  end

  // pick accumulator for a duration event
  always_comb begin
    tgt = idle_acc;
    if (f_q == FN_STATE) begin
      case (st_q)
        ST_TX:   tgt = tx_acc;
        ST_RX:   tgt = rx_acc;
        default: tgt = idle_acc;
      endcase
    end else begin
      tgt = wc_q ? wc_acc : nc_acc;
    end
    acc_sum     = {1'b0, tgt} + {9'd0, dur_q};
    dur_sum_add = acc_sum;
    byte_sum    = {1'b0, (f_q == FN_TX) ? sent_acc : recv_acc} + {33'd0, pb_q};
  end

  logic [AccW-1:0]  acc_sat;
  logic [ByteW-1:0] byte_sat;
  assign acc_sat  = dur_sum_add[AccW] ? MaxAcc : dur_sum_add[AccW-1:0];
  assign byte_sat = byte_sum[ByteW] ? MaxByte : byte_sum[ByteW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      idle_acc <= '0; tx_acc <= '0; rx_acc <= '0; wc_acc <= '0; nc_acc <= '0;
      sent_acc <= '0; recv_acc <= '0;
    end else if (cmd.finish) begin
      idle_acc <= '0; tx_acc <= '0; rx_acc <= '0; wc_acc <= '0; nc_acc <= '0;
      sent_acc <= '0; recv_acc <= '0;
    end else if (cmd.ev_apply) begin
      case (f_q)
        FN_STATE: if (running) begin
          case (st_q)
            ST_IDLE: idle_acc <= acc_sat;
            ST_TX:   tx_acc   <= acc_sat;
            ST_RX:   rx_acc   <= acc_sat;
            default: ;
          endcase
        end
        FN_CCA: if (running) begin
          if (wc_q) wc_acc <= acc_sat;
          else      nc_acc <= acc_sat;
        end
        FN_TX: if (running) sent_acc <= byte_sat;
        FN_RX: if (running) recv_acc <= byte_sat;
        FN_START: if (!running) begin
          running  <= 1'b1;
          idle_acc <= '0; tx_acc <= '0; rx_acc <= '0; wc_acc <= '0; nc_acc <= '0;
          sent_acc <= '0; recv_acc <= '0;
        end
        FN_STOP: running <= 1'b0;
        default: ;
      endcase
    end
  end

  // operand selection for the shared divider
  always_comb begin
    dividend = '0;
    divisor  = DivW'(eff_win);
    case (cmd.job)
      JOB_TX:  dividend = 77'(tx_acc) * 77'(14'd10000);
      JOB_RX:  dividend = 77'(rx_acc) * 77'(14'd10000);
      JOB_WC:  dividend = 77'(wc_acc) * 77'(14'd10000);
      JOB_NC:  dividend = 77'(nc_acc) * 77'(14'd10000);
      JOB_THR: dividend = 77'(sent_acc) * 77'(10'd800);
      JOB_SW: begin
        dividend = 77'(raw_wifi) * 77'(avail);
        divisor  = DivW'(raw_total);
      end
      JOB_SN: begin
        dividend = 77'(raw_non) * 77'(avail);
        divisor  = DivW'(raw_total);
      end
      default: ;
    endcase
  end

  // hold operands stable while iterating
  logic [DivW+16:0] dividend_q;
  logic [DivW-1:0]  divisor_q;
  logic             start_q;
  always_ff @(posedge clk) begin
    if (rst) start_q <= 1'b0;
    else     start_q <= cmd.div_start;
    if (cmd.div_start) begin
      dividend_q <= dividend;
      divisor_q  <= divisor;
    end
  end

  caum_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_q),
    .dividend (dividend_q),
    .divisor  (divisor_q),
    .done     (divs_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.job)
        JOB_TX:  txp <= quotient;
        JOB_RX:  rxp <= quotient;
        JOB_WC:  wcp <= quotient;
        JOB_NC:  ncp <= quotient;
        JOB_THR: thr <= quotient;
        JOB_SW:  sw  <= quotient;
        JOB_SN:  sn  <= quotient;
        default: ;
      endcase
    end
  end

  // shares stay below 2^54, so their sum fits RawW bits exactly
  logic [RawW-1:0] raw_wifi_c, raw_non_c, raw_total_c;
  assign raw_wifi_c  = RawW'(txp) + RawW'(rxp) + RawW'(wcp);
  assign raw_non_c   = RawW'(ncp);
  assign raw_total_c = raw_wifi_c + raw_non_c;
  logic [13:0] avail_c;
  assign avail_c = (vi_q < 14'd10000) ? 14'd10000 - vi_q : 14'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled <= 1'b0;
    end else if (cmd.mix) begin
      raw_wifi  <= raw_wifi_c;
      raw_non   <= raw_non_c;
      raw_total <= raw_total_c;
      avail     <= avail_c;
      scaled    <= (vi_q != '0) && (raw_total_c != '0)
                   && (RawW'(avail_c) < raw_total_c);
    end
  end

  assign sts.need_scale = (vi_q != '0) && (raw_total_c != '0)
                          && (RawW'(avail_c) < raw_total_c);
  assign sts.div_done   = divs_done;
  assign sts.running    = running;

  // final mix; the unscaled interferer branch only sees sums of at most 10000
  logic [20:0] wifi_f, non_f, tot_f;
  always_comb begin
    if (scaled) begin
      wifi_f = 21'(sw);
      non_f  = 21'(sn) + 21'(vi_q);
    end else if (vi_q != '0) begin
      wifi_f = 21'(raw_wifi);
      non_f  = 21'(raw_non) + 21'(vi_q);
    end else begin
      wifi_f = (raw_wifi > RawW'(10000)) ? 21'd10000 : 21'(raw_wifi);
      non_f  = (raw_non > RawW'(21'd10000 - wifi_f)) ? 21'd10000 - wifi_f
                                                      : 21'(raw_non);
    end
    tot_f = wifi_f + non_f;
  end

  function automatic logic [13:0] cl(input logic [20:0] v);
    cl = (v > 21'd10000) ? 14'd10000 : v[13:0];
  endfunction
  function automatic logic [15:0] s16(input logic [QW-1:0] v);
    s16 = (v[QW-1:16] != '0) ? 16'hFFFF : v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      total_pct             <= cl(tot_f);
      wifi_pct              <= cl(wifi_f);
      nonwifi_pct           <= cl(non_f);
      tx_pct                <= s16(txp);
      rx_pct                <= s16(rxp);
      wifi_cca_pct          <= s16(wcp);
      nonwifi_cca_pct       <= s16(ncp);
      throughput_centi_mbps <= (thr[QW-1:32] != '0) ? 32'hFFFF_FFFF : thr[31:0];
      bytes_sent_out        <= sent_acc;
      bytes_received_out    <= recv_acc;
      idle_time_us          <= idle_acc;
    end
  end

endmodule

[hw/rtl/channel_airtime_utilization_monitor.sv]
// Airtime monitor: func 0..3 events are applied in the S_EVENT state; a report while running
// runs five divisions (four shares and throughput) on one restoring divider of
// 77 steps, plus two more when interferer scaling applies. The result waits
// in an output register until taken. Config is taken at any time the block
// is idle.
module channel_airtime_utilization_monitor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[2:0], phy_state[5:3], wifi_caused[6], duration_us[38:7],
  // packet_bytes[54:39], interferer_pct[68:55], zeros
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // total_pct[13:0], wifi_pct[27:14], nonwifi_pct[41:28], tx_pct[57:42],
  // rx_pct[73:58], wifi_cca_pct[89:74], nonwifi_cca_pct[105:90],
  // throughput_centi_mbps[137:106], bytes_sent_out[185:138],
  // bytes_received_out[233:186], idle_time_us[273:234], zeros
  output logic [279:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [26:0]  cfg_data
);
  import caum_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  logic  busy;
  logic  out_free;
  logic [WinW-1:0] window_us;
  logic [13:0] o_tot, o_wifi, o_non;
  logic [15:0] o_tx, o_rx, o_wc, o_nc;
  logic [31:0] o_thr;
  logic [47:0] o_sent, o_recv;
  logic [39:0] o_idle;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) window_us <= WinW'(100000);
    else if (cfg_valid && cfg_ready) window_us <= cfg_data;
  end

  assign out_free = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.finish) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  caum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tdata[2:0]),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  caum_datapath u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .in_take               (s_tvalid && s_tready),
    .func                  (s_tdata[2:0]),
    .phy_state             (s_tdata[5:3]),
    .wifi_caused           (s_tdata[6]),
    .duration_us           (s_tdata[38:7]),
    .packet_bytes          (s_tdata[54:39]),
    .interferer_pct        (s_tdata[68:55]),
    .window_us             (window_us),
    .cmd                   (cmd),
    .sts                   (sts),
    .total_pct             (o_tot),
    .wifi_pct              (o_wifi),
    .nonwifi_pct           (o_non),
    .tx_pct                (o_tx),
    .rx_pct                (o_rx),
    .wifi_cca_pct          (o_wc),
    .nonwifi_cca_pct       (o_nc),
    .throughput_centi_mbps (o_thr),
    .bytes_sent_out        (o_sent),
    .bytes_received_out    (o_recv),
    .idle_time_us          (o_idle)
  );

  assign m_tdata = {6'd0, o_idle, o_recv, o_sent, o_thr, o_nc, o_wc, o_rx, o_tx,
                    o_non, o_wifi, o_tot};

endmodule

[dv/testbench.sv]
module testbench;
  import caum_pkg::*;

  localparam logic [39:0] MaxAcc  = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MaxByte = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] PctFull = 64'd10000;
  localparam int unsigned SettleCycles = 600;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned ItemTarget = 1250;

  typedef struct packed {
    logic [13:0] vi;
    logic [15:0] bytes;
    logic [31:0] dur;
    logic        wifi;
    logic [2:0]  st;
    logic [2:0]  func;
  } event_t;

  typedef struct packed {
    logic [39:0] idle;
    logic [47:0] recv;
    logic [47:0] sent;
    logic [31:0] thr;
    logic [15:0] ncp;
    logic [15:0] wcp;
    logic [15:0] rxp;
    logic [15:0] txp;
    logic [13:0] non;
    logic [13:0] wifi;
    logic [13:0] total;
  } report_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [279:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [26:0] cfg_data = '0;

  channel_airtime_utilization_monitor DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow state of the monitor
  logic [26:0] win_reg;
  logic        is_running;
  logic [39:0] idle_sum, tx_sum, rx_sum, wcca_sum, ncca_sum;
  logic [47:0] sent_sum, recv_sum;

  report_t pending_reports[$];
  int      errors = 0;
  int      items_sent = 0;
  int      reports_seen = 0;
  int      cycles = 0;
  bit      quiet = 0;

  function automatic logic [39:0] add_acc(logic [39:0] a, logic [31:0] v);
    logic [40:0] s;
    s = {1'b0, a} + 41'(v);
    return s > {1'b0, MaxAcc} ? MaxAcc : s[39:0];
  endfunction

  function automatic logic [63:0] win_eff();
    return win_reg == 0 ? 64'd1 : 64'(win_reg);
  endfunction

  function automatic logic [63:0] floor_ratio(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p / 128'(c));
  endfunction

  function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] m);
    return v > m ? m : v;
  endfunction

  task automatic clear_sums();
    idle_sum = 0; tx_sum = 0; rx_sum = 0; wcca_sum = 0; ncca_sum = 0;
    sent_sum = 0; recv_sum = 0;
  endtask

  // update the shadow state; queue a report when one is due
  task automatic predict_report(event_t e);
    logic [63:0] txp, rxp, wcp, ncp, rw, rn, rt, w, n, t, avail;
    logic [48:0] bsum;
    report_t r;
    case (e.func)
      FN_STATE: if (is_running) begin
        if (e.st == ST_IDLE) idle_sum = add_acc(idle_sum, e.dur);
        else if (e.st == ST_TX) tx_sum = add_acc(tx_sum, e.dur);
        else if (e.st == ST_RX) rx_sum = add_acc(rx_sum, e.dur);
      end
      FN_CCA: if (is_running) begin
        if (e.wifi) wcca_sum = add_acc(wcca_sum, e.dur);
        else ncca_sum = add_acc(ncca_sum, e.dur);
      end
      FN_TX: if (is_running) begin
        bsum = {1'b0, sent_sum} + 49'(e.bytes);
        sent_sum = bsum > {1'b0, MaxByte} ? MaxByte : bsum[47:0];
      end
      FN_RX: if (is_running) begin
        bsum = {1'b0, recv_sum} + 49'(e.bytes);
        recv_sum = bsum > {1'b0, MaxByte} ? MaxByte : bsum[47:0];
      end
      FN_START: if (!is_running) begin
        is_running = 1;
        clear_sums();
      end
      FN_STOP: is_running = 0;
      FN_REPORT: if (is_running) begin
        txp = 64'(tx_sum) * PctFull / win_eff();
        rxp = 64'(rx_sum) * PctFull / win_eff();
        wcp = 64'(wcca_sum) * PctFull / win_eff();
        ncp = 64'(ncca_sum) * PctFull / win_eff();
        rw = txp + rxp + wcp;
        rn = ncp;
        rt = rw + rn;
        if (e.vi != 0) begin
          avail = (64'(e.vi) < PctFull) ? PctFull - 64'(e.vi) : 64'd0;
          if (rt > 0 && avail < rt) begin
            w = floor_ratio(rw, avail, rt);
            n = floor_ratio(rn, avail, rt) + 64'(e.vi);
          end else begin
            w = rw;
            n = rn + 64'(e.vi);
          end
        end else begin
          w = clip(rw, PctFull);
          n = clip(rn, PctFull - w);
        end
        t = clip(w + n, PctFull);
        r.total = t[13:0];
        r.wifi = 14'(clip(w, PctFull));
        r.non = 14'(clip(n, PctFull));
        r.txp = 16'(clip(txp, 64'hFFFF));
        r.rxp = 16'(clip(rxp, 64'hFFFF));
        r.wcp = 16'(clip(wcp, 64'hFFFF));
        r.ncp = 16'(clip(ncp, 64'hFFFF));
        r.thr = 32'(clip(64'(sent_sum) * 64'd800 / win_eff(), 64'hFFFF_FFFF));
        r.sent = sent_sum;
        r.recv = recv_sum;
        r.idle = idle_sum;
        pending_reports.push_back(r);
        clear_sums();
      end
      default: ;
    endcase
  endtask

  task automatic send_event(event_t e);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b000, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_report(e);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_window(logic [26:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    win_reg = v;
  endtask

  function automatic event_t make_event(logic [2:0] f, logic [2:0] s, logic w,
                                        logic [31:0] d, logic [15:0] b,
                                        logic [13:0] v);
    event_t e;
    e.func = f; e.st = s; e.wifi = w; e.dur = d; e.bytes = b; e.vi = v;
    return e;
  endfunction

  function automatic event_t rand_event(logic [31:0] dmax);
    event_t e;
    e = make_event(3'($urandom_range(0, 3)), 3'($urandom_range(0, 4)),
                   1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, dmax),
                   16'($urandom), 14'($urandom));
    return e;
  endfunction

  function automatic logic [13:0] rand_vi();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 14'($urandom_range(1, 10000));
      2: return 14'($urandom);
      3: return 14'($urandom_range(9000, 10000));
      default: return 14'($urandom_range(0, 3000));
    endcase
  endfunction

  // compare each result with the oldest pending report
  always @(posedge clk) begin
    report_t got, want;
    if (!rst) m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 28);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[273:0];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("report transfer with none pending");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got != want) begin
          errors++;
          if (got.total != want.total)
            $error("total_pct exp %0d got %0d", want.total, got.total);
          if (got.wifi != want.wifi)
            $error("wifi_pct exp %0d got %0d", want.wifi, got.wifi);
          if (got.non != want.non)
            $error("nonwifi_pct exp %0d got %0d", want.non, got.non);
          if (got.txp != want.txp)
            $error("tx_pct exp %0d got %0d", want.txp, got.txp);
          if (got.rxp != want.rxp)
            $error("rx_pct exp %0d got %0d", want.rxp, got.rxp);
          if (got.wcp != want.wcp)
            $error("wifi_cca_pct exp %0d got %0d", want.wcp, got.wcp);
          if (got.ncp != want.ncp)
            $error("nonwifi_cca_pct exp %0d got %0d", want.ncp, got.ncp);
          if (got.thr != want.thr)
            $error("throughput_centi_mbps exp %0d got %0d", want.thr, got.thr);
          if (got.sent != want.sent)
            $error("bytes_sent_out exp %0d got %0d", want.sent, got.sent);
          if (got.recv != want.recv)
            $error("bytes_received_out exp %0d got %0d", want.recv, got.recv);
          if (got.idle != want.idle)
            $error("idle_time_us exp %0d got %0d", want.idle, got.idle);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    write_window(27'd100);
    send_event(make_event(FN_STATE, ST_TX, 0, 32'd50, 0, 0));   // stopped: dropped
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 0));           // stopped: no report
    send_event(make_event(FN_START, 0, 0, 0, 0, 0));
    send_event(make_event(FN_START, 0, 0, 0, 0, 0));            // already running
    send_event(make_event(FN_STATE, ST_IDLE, 0, 32'hFFFF_FFFF, 0, 0));
    send_event(make_event(FN_STATE, ST_TX, 1, 32'd30, 0, 0));
    send_event(make_event(FN_STATE, ST_RX, 0, 32'd20, 0, 0));
    send_event(make_event(FN_STATE, 3'd1, 0, 32'd999, 0, 0));   // cca busy: counted nowhere
    send_event(make_event(FN_STATE, 3'd4, 0, 32'd999, 0, 0));   // switching
    send_event(make_event(FN_STATE, 3'd7, 1, 32'd999, 0, 0));   // unknown state
    send_event(make_event(FN_CCA, 0, 1, 32'd25, 0, 0));
    send_event(make_event(FN_CCA, 0, 0, 32'd40, 0, 0));
    send_event(make_event(FN_TX, 0, 0, 0, 16'hFFFF, 0));
    send_event(make_event(FN_RX, 0, 0, 0, 16'hFFFF, 0));
    send_event(make_event(3'd7, 3'd7, 1, 32'hFFFF_FFFF, 16'hFFFF, 14'h3FFF));
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 0));           // no interferer, over 100%
    send_event(make_event(FN_STATE, ST_TX, 0, 32'd10, 0, 0));
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 14'h3FFF));    // interferer above full
    send_event(make_event(FN_CCA, 0, 0, 32'd60, 0, 0));
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 14'd5000));    // proportional scaling
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 14'd10000));   // empty window
    send_event(make_event(FN_STOP, 0, 0, 0, 0, 0));
    send_event(make_event(FN_REPORT, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_window_phases();
    logic [26:0] wins[7];
    logic [31:0] dmax;
    int ph, n;
    wins = '{27'd1, 27'd0, 27'd1000, 27'd100000, 27'h7FF_FFFF, 27'd37, 27'd5000};
    ph = 0;
    while (items_sent < ItemTarget) begin
      write_window(ph < 7 ? wins[ph] : 27'($urandom_range(1, 2000000)));
      quiet = (ph % 5 == 3);
      dmax = (win_reg == 0) ? 32'd2 : 32'(win_reg) / 3 + 1;
      // one phase drives the TX and wifi CCA sums into saturation
      if (ph == 2) begin
        send_event(make_event(FN_START, 0, 0, 0, 0, 0));
        repeat (600) send_event(make_event(3'($urandom_range(0, 1)), ST_TX, 1,
          32'hFFFF_FFFF, 0, 0));
        send_event(make_event(FN_REPORT, 0, 0, 0, 0, rand_vi()));
      end
      repeat (12) begin
        if ($urandom_range(0, 4) != 0)
          send_event(make_event(FN_START, 3'($urandom), 1'($urandom), $urandom,
                                16'($urandom), 14'($urandom)));
        n = $urandom_range(1, 12);
        repeat (n) send_event(rand_event(dmax));
        if ($urandom_range(0, 7) == 0)
          send_event(make_event($urandom_range(0, 1) ? FN_STOP : 3'd7,
                                3'($urandom), 1'($urandom), $urandom,
                                16'($urandom), 14'($urandom)));
        send_event(make_event(FN_REPORT, 3'($urandom), 1'($urandom), $urandom,
                              16'($urandom), rand_vi()));
      end
      quiet = 0;
      wait_idle();
      ph++;
    end
  endtask

  initial begin
    win_reg = 27'd100000;
    is_running = 0;
    clear_sums();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_window_phases();
    wait_idle();
    $display("Sent %0d items over several window settings, %0d reports checked.",
             items_sent, reports_seen);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[channel_airtime_utilization_monitor.f]
hw/rtl/caum_pkg.sv
hw/rtl/caum_divider.sv
hw/rtl/caum_ctrl.sv
hw/rtl/caum_datapath.sv
hw/rtl/channel_airtime_utilization_monitor.sv
dv/testbench.sv
